// ===== rtl/lcc_pkg.sv =====
// Shared types, constants and helpers for the LFSR code correlator.
// Used by lcc_channel and lfsr_code_correlator; depends on nothing else.
package lcc_pkg;

   // Round and datapath sizes
   localparam int ROUND_LENGTH = 255;
   localparam int SAMPLE_BITS  = 10;
   localparam int SUM_W        = 20;
   localparam int VALUE_W      = 12;
   localparam int SHIFT_W      = 4;
   localparam int CODE_W       = 8;
   localparam int CNT_W        = $clog2(ROUND_LENGTH + 2);

   // Stream and register port widths
   localparam int REQ_DATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 2 + 2 * VALUE_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = SAMPLE_BITS;

   // Round counter values: one past the round length means no round active
   localparam logic [CNT_W-1:0] ROUND_LAST = CNT_W'(ROUND_LENGTH);
   localparam logic [CNT_W-1:0] IDLE_COUNT = CNT_W'(ROUND_LENGTH + 1);
   localparam logic [CNT_W-1:0] FIRST_COUNT = CNT_W'(1);

   // Code generator constants
   localparam logic [CODE_W-1:0] CODE_MASK = CODE_W'('hB8);
   localparam logic [CODE_W-1:0] SEED_A    = CODE_W'('h01);
   localparam logic [CODE_W-1:0] SEED_B    = CODE_W'('hFF);

   localparam logic [SHIFT_W-1:0] REPORT_SHIFT_RESET = SHIFT_W'(7);

   // Item kinds on the request channel
   localparam logic OP_START  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OFFSET_A     = 2'd0,
      CSR_OFFSET_B     = 2'd1,
      CSR_REPORT_SHIFT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      WEIGHT_ZERO = 2'b00,
      WEIGHT_POS  = 2'b01,
      WEIGHT_NEG  = 2'b11
   } weight_type;

   // Per-item controls sent from the top level to each channel
   typedef struct packed {
      logic load;     // item moves from input stage into processing stage
      logic start;    // that item starts a round
      logic active;   // that item is a sample inside a round
      logic last;     // that sample closes the round
      logic report;   // a closing item moves into the result register
   } ctrl_type;

   // One step of the Galois code generator
   function automatic logic [CODE_W-1:0] lfsr_next(input logic [CODE_W-1:0] r);
      logic [CODE_W-1:0] n;
      n = r >> 1;
      if (r[0]) begin
         n = n ^ CODE_MASK;
      end
      return n;
   endfunction

endpackage

// ===== rtl/lcc_channel.sv =====
// One correlator channel: code generator, weight, correlation sum and
// smoothed value with the shifted, saturated report. Depends on lcc_pkg.
module lcc_channel (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [lcc_pkg::CODE_W-1:0]         seed,
   input  logic [lcc_pkg::SAMPLE_BITS-1:0]    offset,
   input  logic [lcc_pkg::SHIFT_W-1:0]        report_shift,
   input  logic [lcc_pkg::SAMPLE_BITS-1:0]    sample,
   input  lcc_pkg::ctrl_type                  ctrl,
   output logic                               toggle,
   output logic signed [lcc_pkg::VALUE_W-1:0] value
);

   logic [lcc_pkg::CODE_W-1:0]         lfsr_ff;
   lcc_pkg::weight_type                weight_ff;
   logic signed [lcc_pkg::SUM_W-1:0]   acc_ff;
   logic signed [lcc_pkg::SUM_W-1:0]   smoothed_ff;
   logic                               toggle_ff;

   logic [lcc_pkg::CODE_W-1:0]         lfsr_in;
   lcc_pkg::weight_type                weight_in;
   logic                               toggle_in;
   logic                               step;
   logic [lcc_pkg::SAMPLE_BITS:0]      diff;
   logic [lcc_pkg::SAMPLE_BITS-1:0]    diff_clamp;
   logic [lcc_pkg::SUM_W-1:0]          diff_ext;
   logic signed [lcc_pkg::SUM_W-1:0]   acc_in;
   logic signed [lcc_pkg::SUM_W-1:0]   smoothed_in;
   logic signed [lcc_pkg::SUM_W-1:0]   shifted;

   // Code step: new low bit against old one gives toggle and weight
   always_comb begin
      lfsr_in   = lcc_pkg::lfsr_next(lfsr_ff);
      toggle_in = lfsr_in[0] ^ lfsr_ff[0];
      if (lfsr_in[0] && !lfsr_ff[0]) begin
         weight_in = lcc_pkg::WEIGHT_POS;
      end else if (!lfsr_in[0] && lfsr_ff[0]) begin
         weight_in = lcc_pkg::WEIGHT_NEG;
      end else begin
         weight_in = lcc_pkg::WEIGHT_ZERO;
      end
      step = ctrl.start || (ctrl.active && !ctrl.last);
   end

   // Remove the offset, clamp at zero, weight into the sum
   always_comb begin
      diff       = {1'b0, sample} - {1'b0, offset};
      diff_clamp = diff[lcc_pkg::SAMPLE_BITS] ? '0 : diff[lcc_pkg::SAMPLE_BITS-1:0];
      diff_ext   = {{(lcc_pkg::SUM_W - lcc_pkg::SAMPLE_BITS){1'b0}}, diff_clamp};
      case (weight_ff)
         lcc_pkg::WEIGHT_POS: begin
            acc_in = acc_ff + signed'(diff_ext);
         end
         lcc_pkg::WEIGHT_NEG: begin
            acc_in = acc_ff - signed'(diff_ext);
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   // Low-pass the closing sum, then shift and saturate for the report
   always_comb begin
      smoothed_in = (smoothed_ff >>> 1) + (acc_ff >>> 1);
      shifted     = smoothed_in >>> report_shift;
      if ((&shifted[lcc_pkg::SUM_W-1:lcc_pkg::VALUE_W-1]) ||
          !(|shifted[lcc_pkg::SUM_W-1:lcc_pkg::VALUE_W-1])) begin
         value = shifted[lcc_pkg::VALUE_W-1:0];
      end else if (shifted[lcc_pkg::SUM_W-1]) begin
         value = {1'b1, {(lcc_pkg::VALUE_W-1){1'b0}}};
      end else begin
         value = {1'b0, {(lcc_pkg::VALUE_W-1){1'b1}}};
      end
   end

   // Channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff     <= seed;
         weight_ff   <= lcc_pkg::WEIGHT_ZERO;
         acc_ff      <= '0;
         smoothed_ff <= '0;
         toggle_ff   <= 1'b0;
      end else begin
         if (ctrl.load) begin
            toggle_ff <= step & toggle_in;
            if (ctrl.start) begin
               acc_ff <= '0;
            end else if (ctrl.active) begin
               acc_ff <= acc_in;
            end
            if (step) begin
               lfsr_ff   <= lfsr_in;
               weight_ff <= weight_in;
            end
         end
         if (ctrl.report) begin
            smoothed_ff <= smoothed_in;
         end
      end
   end

   assign toggle = toggle_ff;

endmodule

// ===== rtl/lfsr_code_correlator.sv =====
// Two-channel code-division correlator.
// Item path: input register, processing stage, result register.
// Depends on lcc_pkg and lcc_channel.
//
// Use: req_ carries items. req_tuser = 0 starts a capture round (both sums
// cleared, both codes stepped); req_tuser = 1 carries a converter sample in
// req_tdata. Every accepted item yields exactly one rsp_ item: the antenna
// toggles for the current code step and, on the sample that closes a round
// (the 255th after a start), rsp_tuser = 1 with both smoothed values.
// Samples outside a round give an all-zero result. A start inside a round
// restarts it.
// csr_ writes offset_a, offset_b and report_shift; write them while the
// block is idle.
// Throughput: one item per cycle while rsp_tready stays high; each stage
// holds one item and moves when the next stage is empty or moving, so the
// round state updates once per item.
// Reset: codes return to 0x01 (A) and 0xFF (B), sums and smoothed values
// clear, no round is active, report_shift = 7, offsets = 0.
// Stall: while rsp_tready is low the result register holds; the two earlier
// stages keep taking items until they are full, then req_tready drops.
module lfsr_code_correlator (
   input  logic                               clock,
   input  logic                               reset,
   // csr write port
   input  logic                               csr_we,
   input  logic [lcc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lcc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lcc_pkg::REQ_DATA_W-1:0]     req_tdata,   // [9:0] sample, rest zero
   input  logic                               req_tuser,   // [0] op
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lcc_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [0] toggle_a, [1] toggle_b,
                                                          // [13:2] value_a, [25:14] value_b
   output logic                               rsp_tuser    // [0] report_valid
);

   // Configuration registers
   logic [lcc_pkg::SAMPLE_BITS-1:0] offset_a_ff;
   logic [lcc_pkg::SAMPLE_BITS-1:0] offset_b_ff;
   logic [lcc_pkg::SHIFT_W-1:0]     report_shift_ff;

   // Input stage
   logic                            s1_valid_ff;
   logic                            s1_op_ff;
   logic [lcc_pkg::SAMPLE_BITS-1:0] s1_sample_ff;

   // Processing stage
   logic                            s2_valid_ff;
   logic                            s2_final_ff;
   logic [lcc_pkg::CNT_W-1:0]       count_ff;
   logic [lcc_pkg::CNT_W-1:0]       count_in;

   // Result register
   logic                                rsp_valid_ff;
   logic                                rsp_toggle_a_ff;
   logic                                rsp_toggle_b_ff;
   logic                                rsp_report_ff;
   logic signed [lcc_pkg::VALUE_W-1:0]  rsp_value_a_ff;
   logic signed [lcc_pkg::VALUE_W-1:0]  rsp_value_b_ff;

   logic                                s3_ready;
   logic                                s2_ready;
   logic                                s2_move;
   logic                                s1_move;
   logic                                req_accept;
   lcc_pkg::ctrl_type                   ctrl;
   logic                                toggle_a;
   logic                                toggle_b;
   logic signed [lcc_pkg::VALUE_W-1:0]  value_a;
   logic signed [lcc_pkg::VALUE_W-1:0]  value_b;

   // Stage handshakes
   always_comb begin
      s3_ready   = !rsp_valid_ff || rsp_tready;
      s2_move    = s2_valid_ff && s3_ready;
      s2_ready   = !s2_valid_ff || s3_ready;
      s1_move    = s1_valid_ff && s2_ready;
      req_tready = !s1_valid_ff || s2_ready;
      req_accept = req_tvalid && req_tready;
   end

   // Decode the item leaving the input stage against the round counter
   always_comb begin
      ctrl.load   = s1_move;
      ctrl.start  = s1_op_ff == lcc_pkg::OP_START;
      ctrl.active = (s1_op_ff == lcc_pkg::OP_SAMPLE) && (count_ff <= lcc_pkg::ROUND_LAST);
      ctrl.last   = ctrl.active && (count_ff == lcc_pkg::ROUND_LAST);
      ctrl.report = s2_move && s2_final_ff;
      if (ctrl.start) begin
         count_in = lcc_pkg::FIRST_COUNT;
      end else if (ctrl.active) begin
         count_in = count_ff + lcc_pkg::FIRST_COUNT;
      end else begin
         count_in = count_ff;
      end
   end

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_a_ff     <= '0;
         offset_b_ff     <= '0;
         report_shift_ff <= lcc_pkg::REPORT_SHIFT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lcc_pkg::CSR_OFFSET_A: begin
               offset_a_ff <= csr_wdata[lcc_pkg::SAMPLE_BITS-1:0];
            end
            lcc_pkg::CSR_OFFSET_B: begin
               offset_b_ff <= csr_wdata[lcc_pkg::SAMPLE_BITS-1:0];
            end
            lcc_pkg::CSR_REPORT_SHIFT: begin
               report_shift_ff <= csr_wdata[lcc_pkg::SHIFT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Input stage: hold the item until the processing stage takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff     <= req_tuser;
         s1_sample_ff <= req_tdata[lcc_pkg::SAMPLE_BITS-1:0];
      end
   end

   // Processing stage: round counter and closing flag
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s2_final_ff <= 1'b0;
         count_ff    <= lcc_pkg::IDLE_COUNT;
      end else begin
         if (s1_move) begin
            s2_valid_ff <= 1'b1;
            s2_final_ff <= ctrl.last;
            count_ff    <= count_in;
         end else if (s2_move) begin
            s2_valid_ff <= 1'b0;
         end
      end
   end

   lcc_channel u_chan_a (
      .clock        (clock),
      .reset        (reset),
      .seed         (lcc_pkg::SEED_A),
      .offset       (offset_a_ff),
      .report_shift (report_shift_ff),
      .sample       (s1_sample_ff),
      .ctrl         (ctrl),
      .toggle       (toggle_a),
      .value        (value_a)
   );

   lcc_channel u_chan_b (
      .clock        (clock),
      .reset        (reset),
      .seed         (lcc_pkg::SEED_B),
      .offset       (offset_b_ff),
      .report_shift (report_shift_ff),
      .sample       (s1_sample_ff),
      .ctrl         (ctrl),
      .toggle       (toggle_b),
      .value        (value_b)
   );

   // Result register: values only on the closing item
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         rsp_toggle_a_ff <= toggle_a;
         rsp_toggle_b_ff <= toggle_b;
         rsp_report_ff   <= s2_final_ff;
         rsp_value_a_ff  <= s2_final_ff ? value_a : '0;
         rsp_value_b_ff  <= s2_final_ff ? value_b : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_report_ff;
   assign rsp_tdata  = {{lcc_pkg::RSP_PAD_W{1'b0}}, rsp_value_b_ff, rsp_value_a_ff,
                        rsp_toggle_b_ff, rsp_toggle_a_ff};

   // Round counter stays between the first sample and the idle mark
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= lcc_pkg::FIRST_COUNT) && (count_ff <= lcc_pkg::IDLE_COUNT))
      else $error("round counter out of range");

   // A closing result carries no toggles
   a_report_no_toggle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_report_ff |-> !rsp_toggle_a_ff && !rsp_toggle_b_ff)
      else $error("toggle reported on a closing item");

   // Values are zero unless the result closes a round
   a_values_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_report_ff |-> (rsp_value_a_ff == '0) && (rsp_value_b_ff == '0))
      else $error("stale value on a non-closing item");

   // A closing item leaves the round inactive
   a_close_idle: assert property (@(posedge clock) disable iff (reset)
      s1_move && ctrl.last |=> count_ff == lcc_pkg::IDLE_COUNT)
      else $error("round still active after closing sample");

endmodule
